@@ rtl/bgp_pkg.sv @@
// shared types, constants and helpers for the box grid point generator
`timescale 1ns / 1ps

package bgp_pkg;

    localparam int DEF_MAX_ROWS    = 8;
    localparam int DEF_MAX_COLS    = 8;
    localparam int DEF_COORD_WIDTH = 16;
    localparam int DEF_FRAC_BITS   = 4;

    localparam int REG_W       = 4;
    localparam int MARGIN_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int CNT_W       = 5;
    localparam int DV_W        = 4;
    localparam int POS_W       = 4;
    localparam int IDX_W       = 6;
    localparam int TOT_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [REG_W-1:0]    RST_GRID_ROWS    = 4'd8;
    localparam logic [REG_W-1:0]    RST_GRID_COLS    = 4'd8;
    localparam logic [MARGIN_W-1:0] RST_INSET_MARGIN = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_ROWS    = 2'd0,
        REG_GRID_COLS    = 2'd1,
        REG_INSET_MARGIN = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // zero reads as one, anything above the maximum saturates
    function automatic logic [CNT_W-1:0] clamp_count(input logic [REG_W-1:0] v,
                                                     input int maxv);
        logic [CNT_W-1:0] r;
        if (v == '0)
            r = CNT_W'(1);
        else if ({1'b0, v} > CNT_W'(maxv))
            r = CNT_W'(maxv);
        else
            r = {1'b0, v};
        return r;
    endfunction

endpackage

@@ rtl/bgp_front.sv @@
// front end: margin shrink with saturation and per-axis classification
`timescale 1ns / 1ps

module bgp_front #(
    parameter int MAX_ROWS    = bgp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = bgp_pkg::DEF_MAX_COLS,
    parameter int COORD_WIDTH = bgp_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = bgp_pkg::DEF_FRAC_BITS,
    parameter int ENTRY_W     = 2 * (3 * COORD_WIDTH + bgp_pkg::CNT_W + bgp_pkg::DV_W)
) (
    input  logic signed [COORD_WIDTH-1:0]    box_left,
    input  logic signed [COORD_WIDTH-1:0]    box_top,
    input  logic signed [COORD_WIDTH-1:0]    box_right,
    input  logic signed [COORD_WIDTH-1:0]    box_bottom,
    input  logic [bgp_pkg::REG_W-1:0]        grid_rows,
    input  logic [bgp_pkg::REG_W-1:0]        grid_cols,
    input  logic [bgp_pkg::MARGIN_W-1:0]     inset_margin,
    output logic [ENTRY_W-1:0]               entry
);
    import bgp_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int MW   = MARGIN_W + FRAC_BITS;
    localparam int EW   = ((CW > MW) ? CW : MW) + 2;
    localparam int AX_W = 3 * CW + CNT_W + DV_W;

    localparam logic signed [EW-1:0] CMAX_E = {{(EW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    localparam logic signed [EW-1:0] CMIN_E = {{(EW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};

    function automatic logic signed [CW-1:0] shrink(input logic signed [CW-1:0] e,
                                                    input logic [MW-1:0] m,
                                                    input logic sub);
        logic signed [EW-1:0] v;
        logic signed [EW-1:0] mz;
        logic signed [CW-1:0] r;
        v  = EW'(e);
        mz = signed'(EW'(m));
        v  = sub ? (v - mz) : (v + mz);
        if (v > CMAX_E)
            r = CMAX_E[CW-1:0];
        else if (v < CMIN_E)
            r = CMIN_E[CW-1:0];
        else
            r = v[CW-1:0];
        return r;
    endfunction

    // packs {start, end value, span, point count, divisor}
    function automatic logic [AX_W-1:0] axis_pack(input logic signed [CW-1:0] lo,
                                                  input logic signed [CW-1:0] hi,
                                                  input logic [CNT_W-1:0] n);
        logic signed [CW:0] sum;
        logic signed [CW:0] span;
        logic [CW-1:0]      endv;
        logic [CNT_W-1:0]   cnt;
        logic [DV_W-1:0]    dvs;
        sum  = {lo[CW-1], lo} + {hi[CW-1], hi};
        span = {hi[CW-1], hi} - {lo[CW-1], lo};
        // single point axis takes the floored centre
        endv = (n == CNT_W'(1)) ? sum[CW:1] : hi;
        cnt  = ((n != CNT_W'(1)) && !span[CW] && (span != '0)) ? n : CNT_W'(1);
        dvs  = DV_W'(n - CNT_W'(1));
        return {lo, endv, span[CW-1:0], cnt, dvs};
    endfunction

    logic [MW-1:0]         margin_q;
    logic signed [CW-1:0]  in_left;
    logic signed [CW-1:0]  in_top;
    logic signed [CW-1:0]  in_right;
    logic signed [CW-1:0]  in_bottom;
    logic [CNT_W-1:0]      n_rows;
    logic [CNT_W-1:0]      n_cols;

    always_comb
    begin
        margin_q  = MW'(inset_margin) << FRAC_BITS;
        in_left   = shrink(box_left, margin_q, 1'b0);
        in_top    = shrink(box_top, margin_q, 1'b0);
        in_right  = shrink(box_right, margin_q, 1'b1);
        in_bottom = shrink(box_bottom, margin_q, 1'b1);
        n_rows    = clamp_count(grid_rows, MAX_ROWS);
        n_cols    = clamp_count(grid_cols, MAX_COLS);
        entry     = {axis_pack(in_left, in_right, n_cols), axis_pack(in_top, in_bottom, n_rows)};
    end

endmodule

@@ rtl/bgp_queue.sv @@
// short flop queue between front and back
`timescale 1ns / 1ps

module bgp_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = bgp_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [WIDTH-1:0]      push_data,
    input  logic                  pop,
    output logic [WIDTH-1:0]      head,
    output bgp_pkg::q_status_t    status
);
    import bgp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]  mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_QW-1:0] count_reg;
    logic [CNT_QW-1:0] count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_QW'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_QW'(1);
        head         = mem_reg[rd_ptr_reg];
        status.full  = (count_reg == CNT_QW'(DEPTH));
        status.empty = (count_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

@@ rtl/bgp_div.sv @@
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module bgp_div #(
    parameter int COORD_WIDTH = bgp_pkg::DEF_COORD_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [COORD_WIDTH-1:0]        dividend,
    input  logic [bgp_pkg::DV_W-1:0]      divisor,
    output logic                          busy,
    output logic [COORD_WIDTH-1:0]        quotient
);
    import bgp_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int CTW = $clog2(CW + 1);

    logic [CW-1:0]   dq_reg;
    logic [CW-1:0]   dq_next;
    logic [DV_W-1:0] rem_reg;
    logic [DV_W-1:0] rem_next;
    logic [DV_W-1:0] dvs_reg;
    logic [DV_W-1:0] dvs_next;
    logic [CTW-1:0]  cnt_reg;
    logic [CTW-1:0]  cnt_next;
    logic            busy_reg;
    logic            busy_next;
    logic [DV_W:0]   rem_sh;
    logic            q_bit;

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg, dq_reg[CW-1]};
        q_bit     = (rem_sh >= {1'b0, dvs_reg});
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CTW'(CW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // a kept remainder is below the divisor, so it fits
            rem_next = q_bit ? DV_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DV_W-1:0];
            dq_next  = {dq_reg[CW-2:0], q_bit};
            cnt_next = cnt_reg - CTW'(1);
            if (cnt_reg == CTW'(1))
                busy_next = 1'b0;
        end
        busy     = busy_reg;
        quotient = dq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

@@ rtl/bgp_back.sv @@
// back end: step division and row-major point emission
`timescale 1ns / 1ps

module bgp_back #(
    parameter int COORD_WIDTH = bgp_pkg::DEF_COORD_WIDTH,
    parameter int ENTRY_W     = 2 * (3 * COORD_WIDTH + bgp_pkg::CNT_W + bgp_pkg::DV_W)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [ENTRY_W-1:0]             head,
    input  bgp_pkg::q_status_t             q_status,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [COORD_WIDTH-1:0]  point_x,
    output logic signed [COORD_WIDTH-1:0]  point_y,
    output logic [bgp_pkg::IDX_W-1:0]      point_index,
    output logic [bgp_pkg::TOT_W-1:0]      point_count,
    output logic                           last_point
);
    import bgp_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int AX_W = 3 * CW + CNT_W + DV_W;

    logic [AX_W-1:0]  ax_x;
    logic [AX_W-1:0]  ax_y;
    logic             div_busy_x;
    logic             div_busy_y;
    logic [CW-1:0]    step_x;
    logic [CW-1:0]    step_y;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [CW-1:0]    x_lo_reg, x_lo_next, y_lo_reg, y_lo_next;
    logic [CW-1:0]    x_end_reg, x_end_next, y_end_reg, y_end_next;
    logic [CW-1:0]    x_acc_reg, x_acc_next, y_acc_reg, y_acc_next;
    logic [CNT_W-1:0] x_cnt_reg, x_cnt_next, y_cnt_reg, y_cnt_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [POS_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic             out_valid_reg, out_valid_next;
    logic [CW-1:0]    px_reg, px_next, py_reg, py_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [TOT_W-1:0] cnt_out_reg, cnt_out_next;
    logic             last_reg, last_next;
    logic             advance;
    logic             col_end;
    logic             row_end;
    logic [2*CNT_W-1:0] total_full;

    assign ax_x = head[ENTRY_W-1 -: AX_W];
    assign ax_y = head[AX_W-1:0];

    bgp_div #(.COORD_WIDTH(CW)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pop),
        .dividend (ax_x[CNT_W + DV_W +: CW]),
        .divisor  (ax_x[DV_W-1:0]),
        .busy     (div_busy_x),
        .quotient (step_x)
    );

    bgp_div #(.COORD_WIDTH(CW)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pop),
        .dividend (ax_y[CNT_W + DV_W +: CW]),
        .divisor  (ax_y[DV_W-1:0]),
        .busy     (div_busy_y),
        .quotient (step_y)
    );

    always_comb
    begin
        state_next     = state_reg;
        x_lo_next      = x_lo_reg;
        y_lo_next      = y_lo_reg;
        x_end_next     = x_end_reg;
        y_end_next     = y_end_reg;
        x_acc_next     = x_acc_reg;
        y_acc_next     = y_acc_reg;
        x_cnt_next     = x_cnt_reg;
        y_cnt_next     = y_cnt_reg;
        total_next     = total_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        k_next         = k_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        idx_next       = idx_reg;
        cnt_out_next   = cnt_out_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        advance        = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;
        col_end        = ({1'b0, col_reg} == (x_cnt_reg - CNT_W'(1)));
        row_end        = ({1'b0, row_reg} == (y_cnt_reg - CNT_W'(1)));
        total_full     = ax_x[DV_W +: CNT_W] * ax_y[DV_W +: CNT_W];

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    x_lo_next  = ax_x[AX_W-1 -: CW];
                    x_end_next = ax_x[AX_W-1-CW -: CW];
                    x_cnt_next = ax_x[DV_W +: CNT_W];
                    y_lo_next  = ax_y[AX_W-1 -: CW];
                    y_end_next = ax_y[AX_W-1-CW -: CW];
                    y_cnt_next = ax_y[DV_W +: CNT_W];
                    x_acc_next = ax_x[AX_W-1 -: CW];
                    y_acc_next = ax_y[AX_W-1 -: CW];
                    total_next = total_full[TOT_W-1:0];
                    col_next   = '0;
                    row_next   = '0;
                    k_next     = '0;
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                if (!div_busy_x && !div_busy_y)
                    state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (advance)
                begin
                    out_valid_next = 1'b1;
                    // the last point of an axis is its end value exactly
                    px_next        = col_end ? x_end_reg : x_acc_reg;
                    py_next        = row_end ? y_end_reg : y_acc_reg;
                    idx_next       = k_reg;
                    cnt_out_next   = total_reg;
                    last_next      = col_end && row_end;
                    k_next         = k_reg + IDX_W'(1);
                    if (col_end)
                    begin
                        col_next   = '0;
                        x_acc_next = x_lo_reg;
                        if (row_end)
                            state_next = BK_IDLE;
                        else
                        begin
                            row_next   = row_reg + POS_W'(1);
                            y_acc_next = y_acc_reg + step_y;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + POS_W'(1);
                        x_acc_next = x_acc_reg + step_x;
                    end
                end
            end
            default:
                state_next = BK_IDLE;
        endcase

        out_valid   = out_valid_reg;
        point_x     = px_reg;
        point_y     = py_reg;
        point_index = idx_reg;
        point_count = cnt_out_reg;
        last_point  = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_lo_reg    <= x_lo_next;
        y_lo_reg    <= y_lo_next;
        x_end_reg   <= x_end_next;
        y_end_reg   <= y_end_next;
        x_acc_reg   <= x_acc_next;
        y_acc_reg   <= y_acc_next;
        x_cnt_reg   <= x_cnt_next;
        y_cnt_reg   <= y_cnt_next;
        total_reg   <= total_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        idx_reg     <= idx_next;
        cnt_out_reg <= cnt_out_next;
        last_reg    <= last_next;
    end

endmodule

@@ rtl/box_grid_point_generator.sv @@
// a box is queued at its transfer; the back end pops it only when idle, then runs the step dividers
// and then emits the points, so one box is divided and emitted before the next is popped
// the step dividers are bit-serial; the back end emits one point per cycle unless out_stall holds it
// a two-entry queue lets the front take the next boxes while the back is still emitting
// reset: registers return to 8 rows, 8 columns, margin 5; queue empty, no output pending
`timescale 1ns / 1ps

module box_grid_point_generator #(
    parameter int MAX_ROWS    = bgp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = bgp_pkg::DEF_MAX_COLS,
    parameter int COORD_WIDTH = bgp_pkg::DEF_COORD_WIDTH,
    parameter int FRAC_BITS   = bgp_pkg::DEF_FRAC_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bgp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bgp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_WIDTH-1:0]     box_left,
    input  logic signed [COORD_WIDTH-1:0]     box_top,
    input  logic signed [COORD_WIDTH-1:0]     box_right,
    input  logic signed [COORD_WIDTH-1:0]     box_bottom,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [COORD_WIDTH-1:0]     point_x,
    output logic signed [COORD_WIDTH-1:0]     point_y,
    output logic [bgp_pkg::IDX_W-1:0]         point_index,
    output logic [bgp_pkg::TOT_W-1:0]         point_count,
    output logic                              last_point
);
    import bgp_pkg::*;

    localparam int ENTRY_W = 2 * (3 * COORD_WIDTH + CNT_W + DV_W);

    logic [REG_W-1:0]    grid_rows_reg;
    logic [REG_W-1:0]    grid_cols_reg;
    logic [MARGIN_W-1:0] inset_margin_reg;
    logic [ENTRY_W-1:0]  entry;
    logic [ENTRY_W-1:0]  head;
    logic                push;
    logic                pop;
    q_status_t           q_status;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_status.full;
    assign push      = in_valid && !q_status.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg    <= RST_GRID_ROWS;
            grid_cols_reg    <= RST_GRID_COLS;
            inset_margin_reg <= RST_INSET_MARGIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_data[REG_W-1:0];
                REG_GRID_COLS:    grid_cols_reg    <= cfg_data[REG_W-1:0];
                REG_INSET_MARGIN: inset_margin_reg <= cfg_data[MARGIN_W-1:0];
                default:          ;
            endcase
        end
    end

    bgp_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .box_left     (box_left),
        .box_top      (box_top),
        .box_right    (box_right),
        .box_bottom   (box_bottom),
        .grid_rows    (grid_rows_reg),
        .grid_cols    (grid_cols_reg),
        .inset_margin (inset_margin_reg),
        .entry        (entry)
    );

    bgp_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    bgp_back #(
        .COORD_WIDTH (COORD_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_index (point_index),
        .point_count (point_count),
        .last_point  (last_point)
    );

`ifndef SYNTH
    // the final point of a box sits at position count minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_point |-> point_index == IDX_W'(point_count - TOT_W'(1)))
        else $error("last point index does not match point count");

    // the back end only takes an entry that is there
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from an empty queue");

    // a full queue refuses the transfer, so nothing is written past it
    assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full && !pop |=> q_status.full)
        else $error("queue left full state without a pop");
`endif

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the box grid point generator
`timescale 1ns / 1ps

module tb_top;
    import bgp_pkg::*;

    localparam int CW           = DEF_COORD_WIDTH;
    localparam int FB           = DEF_FRAC_BITS;
    localparam int CMAX         = (1 << (CW - 1)) - 1;
    localparam int CMIN         = -(1 << (CW - 1));
    localparam int DRAIN_CYCLES = 2 * (CW + 3);
    localparam int CYCLE_LIMIT  = 1500000;
    localparam int HOLD_OFF     = 300;

    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [IDX_W-1:0]     idx;
        logic [TOT_W-1:0]     cnt;
        logic                 is_last;
    } grid_point_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [CW-1:0]  box_left;
    logic signed [CW-1:0]  box_top;
    logic signed [CW-1:0]  box_right;
    logic signed [CW-1:0]  box_bottom;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [CW-1:0]  point_x;
    logic signed [CW-1:0]  point_y;
    logic [IDX_W-1:0]      point_index;
    logic [TOT_W-1:0]      point_count;
    logic                  last_point;

    // register mirror
    logic [REG_W-1:0]    cur_rows   = RST_GRID_ROWS;
    logic [REG_W-1:0]    cur_cols   = RST_GRID_COLS;
    logic [MARGIN_W-1:0] cur_margin = RST_INSET_MARGIN;

    grid_point_t expected_points[$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;
    bit          steady_flow = 1'b0;

    box_grid_point_generator i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .box_left    (box_left),
        .box_top     (box_top),
        .box_right   (box_right),
        .box_bottom  (box_bottom),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_index (point_index),
        .point_count (point_count),
        .last_point  (last_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d points outstanding", $time, expected_points.size());
            $display("[box_grid_point_generator] ERROR");
            $finish;
        end
    end

    function automatic int sat_coord(input int v);
        if (v > CMAX)
            return CMAX;
        if (v < CMIN)
            return CMIN;
        return v;
    endfunction

    function automatic int eff_count(input logic [REG_W-1:0] v, input int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic int axis_count(input int lo, input int hi, input int n);
        if (n == 1 || hi - lo <= 0)
            return 1;
        return n;
    endfunction

    function automatic int axis_point(input int lo, input int hi, input int n, input int i);
        if (n == 1)
            return (lo + hi) >>> 1;
        if (hi - lo <= 0 || i == n - 1)
            return hi;
        return lo + i * ((hi - lo) / (n - 1));
    endfunction

    // shrinks the box by the margin and queues every grid point it yields
    function automatic void predict_grid_points(input logic signed [CW-1:0] l,
                                                input logic signed [CW-1:0] t,
                                                input logic signed [CW-1:0] r,
                                                input logic signed [CW-1:0] b);
        int m;
        int lo_x, hi_x, lo_y, hi_y;
        int nc, nr, nx, ny, total, k;
        grid_point_t p;
        m     = int'(cur_margin) << FB;
        lo_x  = sat_coord(int'(l) + m);
        lo_y  = sat_coord(int'(t) + m);
        hi_x  = sat_coord(int'(r) - m);
        hi_y  = sat_coord(int'(b) - m);
        nc    = eff_count(cur_cols, DEF_MAX_COLS);
        nr    = eff_count(cur_rows, DEF_MAX_ROWS);
        nx    = axis_count(lo_x, hi_x, nc);
        ny    = axis_count(lo_y, hi_y, nr);
        total = nx * ny;
        k     = 0;
        for (int yi = 0; yi < ny; yi++)
        begin
            for (int xi = 0; xi < nx; xi++)
            begin
                p.x       = CW'(axis_point(lo_x, hi_x, nc, xi));
                p.y       = CW'(axis_point(lo_y, hi_y, nr, yi));
                p.idx     = IDX_W'(k);
                p.cnt     = TOT_W'(total);
                p.is_last = (k == total - 1);
                expected_points = {expected_points, p};
                k++;
            end
        end
    endfunction

    // point checker
    always @(posedge clk)
    begin : check_points
        grid_point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_points.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected point x=%0d y=%0d index=%0d count=%0d last=%0b",
                         $time, point_x, point_y, point_index, point_count, last_point);
            end
            else
            begin
                want = expected_points.pop_front();
                if (want.x !== point_x || want.y !== point_y || want.idx !== point_index ||
                    want.cnt !== point_count || want.is_last !== last_point)
                begin
                    fail_count++;
                    $display({"%0t: point mismatch expected x=%0d y=%0d index=%0d count=%0d ",
                              "last=%0b got x=%0d y=%0d index=%0d count=%0d last=%0b"},
                             $time, want.x, want.y, want.idx, want.cnt, want.is_last,
                             point_x, point_y, point_index, point_count, last_point);
                end
            end
        end
    end

    // receiver: random stall before each transfer outside steady flow, long hold-off on request
    initial
    begin : point_receiver
        int n;
        forever
        begin
            if (hold_cycles != 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = steady_flow ? 0 : $urandom_range(0, 7);
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // returns with in_valid still high so back-to-back boxes need no extra step
    task automatic send_box(input logic signed [CW-1:0] l, input logic signed [CW-1:0] t,
                            input logic signed [CW-1:0] r, input logic signed [CW-1:0] b);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        box_left   <= l;
        box_top    <= t;
        box_right  <= r;
        box_bottom <= b;
        do @(posedge clk); while (in_stall);
        predict_grid_points(l, t, r, b);
    endtask

    task automatic send_random_box();
        int kind, x0, y0, w, h, m2;
        kind = $urandom_range(0, 9);
        m2   = 2 * (int'(cur_margin) << FB);
        x0   = int'($urandom_range(0, 65535)) - 32768;
        y0   = int'($urandom_range(0, 65535)) - 32768;
        if (kind < 2)
            send_box(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
        else
        begin
            if (kind < 8)
            begin
                w = m2 + int'($urandom_range(0, 8000));
                h = m2 + int'($urandom_range(0, 8000));
            end
            else if (kind == 8)
            begin
                // small spans around zero, often below the point count: repeated start values
                w = m2 + int'($urandom_range(0, 12)) - 2;
                h = m2 + int'($urandom_range(0, 12)) - 2;
            end
            else
            begin
                w = -int'($urandom_range(1, 3000));
                h = $urandom_range(0, 1) ? -int'($urandom_range(0, 3000)) :
                                           m2 + int'($urandom_range(0, 4000));
            end
            send_box(CW'(x0), CW'(y0), CW'(sat_coord(x0 + w)), CW'(sat_coord(y0 + h)));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_GRID_ROWS:    cur_rows   = data[REG_W-1:0];
            REG_GRID_COLS:    cur_cols   = data[REG_W-1:0];
            REG_INSET_MARGIN: cur_margin = data[MARGIN_W-1:0];
            default:          ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] rows, input logic [CFG_DATA_W-1:0] cols,
                              input logic [CFG_DATA_W-1:0] margin);
        wait_drained();
        write_reg(REG_GRID_ROWS, rows);
        write_reg(REG_GRID_COLS, cols);
        write_reg(REG_INSET_MARGIN, margin);
    endtask

    task automatic test_reset_defaults();
        send_box(0, 0, 1600, 1600);
        send_box(-800, -800, 800, 800);
    endtask

    task automatic test_field_extremes();
        set_config(8'd8, 8'd8, 8'd0);
        send_box(-32768, -32768, 32767, 32767);
        send_box(32767, 32767, -32768, -32768);
        send_box(16'sh5555, 16'shAAAA, 16'sh7FFF, 16'sh0000);
        // margin pushes the edges past the range
        set_config(8'd8, 8'd8, 8'd255);
        send_box(32767, 32767, -32768, -32768);
        send_box(-32768, -32768, 32767, 32767);
    endtask

    task automatic test_count_clamp();
        // zero rows read as one, fifteen columns saturate
        set_config(8'h00, 8'h0F, 8'd0);
        send_box(0, -7, 160, -2);
        send_box(-32768, -32768, -32767, -32768);
        // upper data bits carry no meaning for the count registers
        set_config(8'hF0, 8'h01, 8'd3);
        send_box(-3, 5, 10, 6);
        send_box(32767, 32767, 32767, 32767);
        set_config(8'h09, 8'h02, 8'd0);
        write_reg(REG_UNUSED_IDX, 8'hFF);
        send_box(-1000, -1000, 1000, 1000);
    endtask

    task automatic test_special_cases();
        set_config(8'd8, 8'd8, 8'd0);
        send_box(0, 0, 5, 3);
        send_box(100, 200, 107, 207);
        send_box(300, 300, 300, 250);
        // edges cross or meet once the margin is taken off
        set_config(8'd4, 8'd4, 8'd100);
        send_box(0, 0, 1000, 4000);
        send_box(0, 0, 3200, 3201);
    endtask

    task automatic test_random_grids();
        for (int ph = 0; ph < 11; ph++)
        begin
            if (ph == 0)
                set_config(8'd8, 8'd8, 8'd0);
            else if (ph == 1)
                set_config(8'd1, 8'd1, 8'd255);
            else if (ph == 2)
                set_config(8'd8, 8'd1, 8'd0);
            else
                set_config(8'($urandom), 8'($urandom),
                           $urandom_range(0, 1) ? 8'($urandom_range(0, 40)) : 8'($urandom));
            steady_flow = (ph == 5);
            repeat (30) send_random_box();
        end
        steady_flow = 1'b0;
    endtask

    task automatic test_input_backpressure();
        set_config(8'd8, 8'd8, 8'd0);
        steady_flow = 1'b1;
        hold_cycles = HOLD_OFF;
        repeat (20) send_random_box();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_GRID_ROWS;
        cfg_data   <= '0;
        in_valid   <= 1'b0;
        box_left   <= '0;
        box_top    <= '0;
        box_right  <= '0;
        box_bottom <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_field_extremes();
        test_count_clamp();
        test_special_cases();
        test_random_grids();
        test_input_backpressure();
        wait_drained();
        if (fail_count == 0)
            $display("[box_grid_point_generator] OK");
        else
            $display("[box_grid_point_generator] ERROR");
        $finish;
    end

endmodule
